FILE: rtl/cfr_pkg.sv
// cfr_pkg: shared constants and control/status types for the command frame receiver
// no dependencies; imported by cfr_ctrl, cfr_datapath and command_frame_receiver_core
package cfr_pkg;

	localparam logic [7:0] SOP_BYTE    = 8'hA5;
	localparam logic [7:0] EOP_BYTE    = 8'h5A;
	localparam logic [7:0] CMD_MONITOR = 8'h01;
	localparam logic [7:0] CMD_SETVAR  = 8'h02;
	localparam logic [7:0] CMD_RATE    = 8'h03;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_CHECKSUM   = 3'd1;
	localparam logic [2:0] ST_UNKNOWN    = 3'd2;
	localparam logic [2:0] ST_BAD_LEN    = 3'd3;
	localparam logic [2:0] ST_BAD_TYPE   = 3'd4;
	localparam logic [2:0] ST_TOO_MANY   = 3'd5;

	localparam int HEAD_DEPTH = 9;
	localparam int HIDX_W     = 4;

	localparam logic [7:0] VAR_TYPE_RSVD = 8'd7;
	localparam logic [7:0] VAR_TYPE_MAX  = 8'd8;
	localparam int         SETVAR_LEN    = 9;
	localparam int         RATE_LEN      = 4;
	localparam int         MON_ENTRY     = 5;

	// period numerator and restoring divider geometry
	localparam int NUM_W    = 10;
	localparam int DCNT_W   = 4;
	localparam logic [NUM_W-1:0] RATE_NUM = NUM_W'(1000);

	localparam int OUT_W = 40;

	typedef struct packed {
		logic ld_cmd;
		logic ld_len_lo;
		logic ld_len_hi;
		logic ld_data;
		logic emit_sum;
		logic emit_chk;
		logic div_start;
	} cfr_cmd_t;

	typedef struct packed {
		logic sop_hit;
		logic len_over;
		logic len_zero;
		logic data_last;
		logic sum_ok;
		logic eop_ok;
		logic need_div;
		logic div_done;
		logic out_hold;
	} cfr_stat_t;

endpackage

FILE: rtl/cfr_ctrl.sv
// cfr_ctrl: frame phase state machine, issues datapath commands per received byte
// depends on cfr_pkg
module cfr_ctrl import cfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  cfr_stat_t stat,
	output cfr_cmd_t  cmd
);

	typedef enum logic [2:0] {
		PH_SOP, PH_CMD, PH_LEN1, PH_LEN2, PH_DATA, PH_SUM, PH_EOP, PH_DIV
	} phase_t;

	phase_t phase_q;
	phase_t phase_d;
	logic   fire;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b1;
		phase_d  = phase_q;
		unique case (phase_q)
			PH_SUM, PH_EOP: in_ready = !stat.out_hold;
			PH_DIV: in_ready = 1'b0;
			default: in_ready = 1'b1;
		endcase
		fire = in_valid && in_ready;
		unique case (phase_q)
			PH_SOP: begin
				if (fire && stat.sop_hit) phase_d = PH_CMD;
			end
			PH_CMD: begin
				cmd.ld_cmd = fire;
				if (fire) phase_d = PH_LEN1;
			end
			PH_LEN1: begin
				cmd.ld_len_lo = fire;
				if (fire) phase_d = PH_LEN2;
			end
			PH_LEN2: begin
				cmd.ld_len_hi = fire;
				if (fire) begin
					if (stat.len_over) phase_d = PH_SOP;
					else if (stat.len_zero) phase_d = PH_SUM;
					else phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				cmd.ld_data = fire;
				if (fire && stat.data_last) phase_d = PH_SUM;
			end
			PH_SUM: begin
				if (fire) begin
					if (stat.sum_ok) begin
						phase_d = PH_EOP;
					end else begin
						cmd.emit_sum = 1'b1;
						phase_d      = PH_SOP;
					end
				end
			end
			PH_EOP: begin
				if (fire) begin
					phase_d = PH_SOP;
					if (stat.eop_ok) begin
						if (stat.need_div) begin
							cmd.div_start = 1'b1;
							phase_d       = PH_DIV;
						end else begin
							cmd.emit_chk = 1'b1;
						end
					end
				end
			end
			PH_DIV: begin
				if (stat.div_done && !stat.out_hold) begin
					cmd.emit_chk = 1'b1;
					phase_d      = PH_SOP;
				end
			end
			default: phase_d = PH_SOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SOP;
		end else begin
			phase_q <= phase_d;
		end
	end

endmodule

FILE: rtl/cfr_datapath.sv
// cfr_datapath: frame fields, checksum, payload head, period divider and result register
// depends on cfr_pkg; driven by cfr_ctrl commands
module cfr_datapath import cfr_pkg::*; #(
	parameter int BUFFER_BYTES = 128,
	parameter int MAX_VARS     = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_byte,
	input  logic [15:0]      dflt_period,
	input  cfr_cmd_t         cmd,
	output cfr_stat_t        stat,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	localparam int CW = $clog2(BUFFER_BYTES + 1);

	logic [7:0]       fcmd_q;
	logic [15:0]      len_q;
	logic [CW-1:0]    cnt_q;
	logic [7:0]       xor_q;
	logic [7:0]       head_q [HEAD_DEPTH];

	logic [NUM_W-1:0]  div_rem_q;
	logic [NUM_W-1:0]  div_dvd_q;
	logic [NUM_W-1:0]  div_quo_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              div_busy_q;
	logic              div_done_q;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic [15:0]      len_new;
	logic [CW-1:0]    cnt_inc;
	logic [31:0]      rate;
	logic             rate_zero;
	logic             rate_big;
	logic [NUM_W:0]   rem_shift;
	logic [NUM_W:0]   divisor;
	logic             div_ge;
	logic [7:0]       mon_n;
	logic [15:0]      mon_len;
	logic [2:0]       r_status;
	logic             r_pupd;
	logic [15:0]      r_period;
	logic             r_mupd;
	logic [3:0]       r_mcnt;

	assign len_new   = {in_byte, len_q[7:0]};
	assign cnt_inc   = cnt_q + 1'b1;
	assign rate      = {head_q[3], head_q[2], head_q[1], head_q[0]};
	assign rate_zero = (rate == 32'd0);
	assign rate_big  = (rate > 32'(RATE_NUM));

	assign stat.sop_hit   = (in_byte == SOP_BYTE);
	assign stat.len_over  = (len_new > 16'(BUFFER_BYTES));
	assign stat.len_zero  = (len_new == 16'd0);
	assign stat.data_last = (16'(cnt_inc) >= len_q);
	assign stat.sum_ok    = (in_byte == xor_q);
	assign stat.eop_ok    = (in_byte == EOP_BYTE);
	assign stat.need_div  = (fcmd_q == CMD_RATE) && (len_q == 16'(RATE_LEN))
	                        && !rate_zero && !rate_big;
	assign stat.div_done  = div_done_q;
	assign stat.out_hold  = out_valid_q && !out_ready;

	// restoring division step of the period numerator by the rate
	assign divisor   = {1'b0, rate[NUM_W-1:0]};
	assign rem_shift = {div_rem_q, div_dvd_q[NUM_W-1]};
	assign div_ge    = (rem_shift >= divisor);

	// frame check
	always_comb begin
		r_status = ST_OK;
		r_pupd   = 1'b0;
		r_period = 16'd0;
		r_mupd   = 1'b0;
		r_mcnt   = 4'd0;
		mon_n    = (len_q == 16'd0) ? 8'd0 : head_q[0];
		mon_len  = 16'd1 + 16'(mon_n) * 16'(MON_ENTRY);
		case (fcmd_q)
			CMD_MONITOR: begin
				r_mupd = 1'b1;
				if (mon_n == 8'd0) r_status = ST_OK;
				else if (mon_n > 8'(MAX_VARS)) r_status = ST_TOO_MANY;
				else if (len_q != mon_len) r_status = ST_BAD_LEN;
				else r_mcnt = mon_n[3:0];
			end
			CMD_SETVAR: begin
				if (len_q != 16'(SETVAR_LEN)) r_status = ST_BAD_LEN;
				else if (head_q[4] == VAR_TYPE_RSVD || head_q[4] > VAR_TYPE_MAX)
					r_status = ST_BAD_TYPE;
			end
			CMD_RATE: begin
				if (len_q != 16'(RATE_LEN)) begin
					r_status = ST_BAD_LEN;
				end else begin
					r_pupd = 1'b1;
					if (rate_zero) r_period = (dflt_period == 16'd0) ? 16'd1 : dflt_period;
					else if (rate_big) r_period = 16'd1;
					else r_period = 16'(div_quo_q);
				end
			end
			default: r_status = ST_UNKNOWN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcmd_q      <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			xor_q       <= '0;
			div_busy_q  <= 1'b0;
			div_done_q  <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ld_cmd) begin
				fcmd_q <= in_byte;
				xor_q  <= in_byte;
			end
			if (cmd.ld_len_lo) begin
				len_q <= {8'd0, in_byte};
				xor_q <= xor_q ^ in_byte;
			end
			if (cmd.ld_len_hi) begin
				len_q <= len_new;
				cnt_q <= '0;
				xor_q <= xor_q ^ in_byte;
			end
			if (cmd.ld_data) begin
				cnt_q <= cnt_inc;
				xor_q <= xor_q ^ in_byte;
			end
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_done_q <= 1'b0;
				div_cnt_q  <= '0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == DCNT_W'(NUM_W - 1)) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end else if (cmd.emit_chk) begin
				div_done_q <= 1'b0;
			end
			if (cmd.emit_sum || cmd.emit_chk) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_data && (cnt_q < CW'(HEAD_DEPTH))) begin
			head_q[cnt_q[HIDX_W-1:0]] <= in_byte;
		end
		if (cmd.div_start) begin
			div_rem_q <= '0;
			div_dvd_q <= RATE_NUM;
			div_quo_q <= '0;
		end else if (div_busy_q) begin
			div_rem_q <= div_ge ? NUM_W'(rem_shift - divisor) : rem_shift[NUM_W-1:0];
			div_dvd_q <= {div_dvd_q[NUM_W-2:0], 1'b0};
			div_quo_q <= {div_quo_q[NUM_W-2:0], div_ge};
		end
		if (cmd.emit_sum) begin
			out_data_q <= {7'd0, 4'd0, 1'b0, 16'd0, 1'b0, ST_CHECKSUM, fcmd_q};
		end else if (cmd.emit_chk) begin
			out_data_q <= {7'd0, r_mcnt, r_mupd, r_period, r_pupd, r_status, fcmd_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: rtl/command_frame_receiver_core.sv
// command_frame_receiver_core: top level of the command frame receiver
// depends on cfr_pkg, cfr_ctrl and cfr_datapath
//
// Takes one received byte per transaction and deframes start byte, command, 16-bit
// little-endian length, payload, XOR checksum and end byte. Bytes are accepted back
// to back; the input stalls at a checksum or end byte only while an earlier
// acknowledge is still waiting on the output. A good set-rate frame with a rate from
// 1 to 1000 runs a ten-step restoring divider after its end byte, and the input is
// held until the divider is done and its acknowledge can be issued.
// Frames longer than BUFFER_BYTES or with a bad end byte give no acknowledge.
module command_frame_receiver_core import cfr_pkg::*; #(
	parameter int BUFFER_BYTES = 128,
	parameter int MAX_VARS     = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [15:0]      cfg_data,       // dflt_period
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // rx_byte
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// ack_cmd[7:0], ack_status[10:8], period_update[11], new_period[27:12],
	// monitor_update[28], monitor_count[32:29], zero fill[39:33]
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic [15:0] dflt_period_q;
	cfr_cmd_t    cmd;
	cfr_stat_t   stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_period_q <= 16'd10;
		end else if (cfg_valid) begin
			dflt_period_q <= cfg_data;
		end
	end

	cfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cfr_datapath #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.MAX_VARS     (MAX_VARS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (s_axis_tdata),
		.dflt_period (dflt_period_q),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata)
	);

endmodule

FILE: verif/command_frame_receiver_core_test.sv
`timescale 1ns / 100ps
// command_frame_receiver_core_test: self-checking testbench for the command frame receiver
// streams framed command bytes with random gaps and back-pressure, predicts every acknowledge
// depends on cfr_pkg and command_frame_receiver_core
module command_frame_receiver_core_test;
	import cfr_pkg::*;

	localparam int BUFFER_BYTES = 128;
	localparam int MAX_VARS     = 10;

	typedef enum logic [2:0] {
		RX_SOP, RX_CMD, RX_LEN_LO, RX_LEN_HI, RX_DATA, RX_SUM, RX_EOP
	} rx_phase_t;

	typedef enum logic [1:0] {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_EOP} frame_flaw_t;

	typedef struct packed {
		logic [7:0]  cmd;
		logic [2:0]  status;
		logic        per_upd;
		logic [15:0] period;
		logic        mon_upd;
		logic [3:0]  mon_cnt;
	} ack_t;

	typedef logic [7:0] byte_q_t [$];

	class ack_tracker_t;
		rx_phase_t   phase;
		logic [7:0]  cmd;
		logic [15:0] len;
		int          count;
		logic [7:0]  sum;
		logic [7:0]  head [HEAD_DEPTH];
		logic [15:0] period_dflt;
		ack_t        acks_due [$];
		int          errors;

		function new();
			phase = RX_SOP;
			cmd = '0;
			len = '0;
			count = 0;
			sum = '0;
			period_dflt = 16'd10;
			errors = 0;
			foreach (head[i]) head[i] = '0;
		endfunction

		function int pending();
			return acks_due.size();
		endfunction

		function void set_period_dflt(logic [15:0] v);
			period_dflt = v;
		endfunction

		function string ack_text(ack_t a);
			return $sformatf("cmd %h st %0d pu %0b per %0d mu %0b cnt %0d", a.cmd,
				a.status, a.per_upd, a.period, a.mon_upd, a.mon_cnt);
		endfunction

		function void judge_frame();
			ack_t        a;
			int unsigned n;
			int unsigned rate;
			int unsigned per;
			a = '0;
			a.cmd = cmd;
			if (cmd == CMD_MONITOR) begin
				n = (len == 0) ? 0 : head[0];
				a.mon_upd = 1'b1;
				if (n == 0) begin
					a.status = ST_OK;
				end else if (n > MAX_VARS) begin
					a.status = ST_TOO_MANY;
				end else if (int'(len) != 1 + MON_ENTRY * n) begin
					a.status = ST_BAD_LEN;
				end else begin
					a.status = ST_OK;
					a.mon_cnt = n[3:0];
				end
			end else if (cmd == CMD_SETVAR) begin
				if (int'(len) != SETVAR_LEN)
					a.status = ST_BAD_LEN;
				else if (head[4] == VAR_TYPE_RSVD || head[4] > VAR_TYPE_MAX)
					a.status = ST_BAD_TYPE;
				else
					a.status = ST_OK;
			end else if (cmd == CMD_RATE) begin
				if (int'(len) != RATE_LEN) begin
					a.status = ST_BAD_LEN;
				end else begin
					rate = {head[3], head[2], head[1], head[0]};
					per = (rate == 0) ? period_dflt : 1000 / rate;
					if (per == 0)
						per = 1;
					a.status = ST_OK;
					a.per_upd = 1'b1;
					a.period = per[15:0];
				end
			end else begin
				a.status = ST_UNKNOWN;
			end
			acks_due.push_back(a);
		endfunction

		function void take_byte(logic [7:0] b);
			ack_t a;
			case (phase)
				RX_CMD: begin
					cmd = b;
					sum ^= b;
					phase = RX_LEN_LO;
				end
				RX_LEN_LO: begin
					len = {8'h00, b};
					sum ^= b;
					phase = RX_LEN_HI;
				end
				RX_LEN_HI: begin
					len[15:8] = b;
					sum ^= b;
					if (len > BUFFER_BYTES) begin
						phase = RX_SOP;
					end else if (len == 0) begin
						phase = RX_SUM;
					end else begin
						count = 0;
						phase = RX_DATA;
					end
				end
				RX_DATA: begin
					if (count < HEAD_DEPTH)
						head[count] = b;
					count++;
					sum ^= b;
					if (count >= len)
						phase = RX_SUM;
				end
				RX_SUM: begin
					if (b == sum) begin
						phase = RX_EOP;
					end else begin
						phase = RX_SOP;
						a = '0;
						a.cmd = cmd;
						a.status = ST_CHECKSUM;
						acks_due.push_back(a);
					end
				end
				RX_EOP: begin
					phase = RX_SOP;
					if (b == EOP_BYTE)
						judge_frame();
				end
				default: begin
					phase = RX_SOP;
					if (b == SOP_BYTE) begin
						phase = RX_CMD;
						sum = '0;
					end
				end
			endcase
		endfunction

		function void match_ack(logic [OUT_W-1:0] d);
			ack_t got;
			ack_t want;
			got.cmd     = d[7:0];
			got.status  = d[10:8];
			got.per_upd = d[11];
			got.period  = d[27:12];
			got.mon_upd = d[28];
			got.mon_cnt = d[32:29];
			if (acks_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected ack transaction: %h", d);
				return;
			end
			want = acks_due.pop_front();
			if (got.cmd !== want.cmd || got.status !== want.status ||
			    got.per_upd !== want.per_upd || got.period !== want.period ||
			    got.mon_upd !== want.mon_upd || got.mon_cnt !== want.mon_cnt) begin
				errors++;
				if (errors <= 10)
					$display("ack mismatch: expected %s, got %s", ack_text(want),
						ack_text(got));
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [15:0]      cfg_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	ack_tracker_t board = new();
	bit           tx_idle = 1'b1;
	bit           rx_idle = 1'b1;
	int           hold_cycles = 0;
	int           frame_bytes = 0;

	command_frame_receiver_core #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.MAX_VARS(MAX_VARS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#8_000_000;
		$display("status: fail");
		$finish;
	end

	// acknowledge sink with random and long stalls
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		forever begin
			gap = hold_cycles + (rx_idle ? $urandom_range(0, 9) : 0);
			hold_cycles = 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			board.match_ack(m_axis_tdata);
		end
	end

	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.take_byte(b);
	endtask

	function automatic logic [7:0] quiet_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == SOP_BYTE);
		return b;
	endfunction

	function automatic byte_q_t noise_bytes(int n);
		byte_q_t q;
		repeat (n) q.push_back(8'($urandom));
		return q;
	endfunction

	function automatic byte_q_t headed_bytes(logic [7:0] first, int n);
		byte_q_t q;
		q = noise_bytes(n);
		if (n > 0)
			q[0] = first;
		return q;
	endfunction

	function automatic byte_q_t setvar_bytes(logic [7:0] vtype);
		byte_q_t q;
		q = noise_bytes(SETVAR_LEN);
		q[4] = vtype;
		return q;
	endfunction

	function automatic byte_q_t rate_bytes(logic [31:0] rate);
		byte_q_t q;
		q.push_back(rate[7:0]);
		q.push_back(rate[15:8]);
		q.push_back(rate[23:16]);
		q.push_back(rate[31:24]);
		return q;
	endfunction

	task automatic send_frame(logic [7:0] cmd, byte_q_t pl, frame_flaw_t flaw);
		logic [15:0] len;
		logic [7:0]  sum;
		logic [7:0]  b;
		len = 16'(pl.size());
		sum = cmd ^ len[7:0] ^ len[15:8];
		foreach (pl[i]) sum ^= pl[i];
		send_byte(SOP_BYTE);
		send_byte(cmd);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		foreach (pl[i]) send_byte(pl[i]);
		if (flaw == FRAME_BAD_SUM)
			send_byte(sum ^ 8'($urandom_range(1, 255)));
		else
			send_byte(sum);
		if (flaw == FRAME_BAD_EOP) begin
			b = 8'($urandom);
			if (b == EOP_BYTE)
				b = ~b;
			send_byte(b);
		end else begin
			send_byte(EOP_BYTE);
		end
		frame_bytes += pl.size() + 6;
	endtask

	task automatic send_oversize(logic [7:0] cmd, logic [15:0] len);
		send_byte(SOP_BYTE);
		send_byte(cmd);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		repeat ($urandom_range(1, 4)) send_byte(quiet_byte());
		frame_bytes += 4;
	endtask

	task automatic send_random_frame();
		int          kind;
		int          n;
		int          len;
		logic [7:0]  cmd;
		logic [31:0] rate;
		frame_flaw_t flaw;
		byte_q_t     pl;
		case ($urandom_range(0, 19))
			0: flaw = FRAME_BAD_SUM;
			1: flaw = FRAME_BAD_EOP;
			default: flaw = FRAME_GOOD;
		endcase
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			case ($urandom_range(0, 9))
				0: pl = noise_bytes(0);
				1: pl = headed_bytes(8'd0, $urandom_range(1, 6));
				2: pl = headed_bytes(8'($urandom_range(MAX_VARS + 1, 255)),
					$urandom_range(1, 40));
				3: begin
					n = $urandom_range(1, MAX_VARS);
					do len = $urandom_range(1, 60); while (len == 1 + MON_ENTRY * n);
					pl = headed_bytes(8'(n), len);
				end
				default: begin
					n = $urandom_range(1, MAX_VARS);
					pl = headed_bytes(8'(n), 1 + MON_ENTRY * n);
				end
			endcase
			send_frame(CMD_MONITOR, pl, flaw);
		end else if (kind < 45) begin
			if ($urandom_range(0, 4) == 0) begin
				do len = $urandom_range(0, 20); while (len == SETVAR_LEN);
				pl = noise_bytes(len);
			end else begin
				case ($urandom_range(0, 3))
					0: pl = setvar_bytes(VAR_TYPE_RSVD);
					1: pl = setvar_bytes(8'($urandom_range(9, 255)));
					default: pl = setvar_bytes(8'($urandom_range(0, 8)));
				endcase
			end
			send_frame(CMD_SETVAR, pl, flaw);
		end else if (kind < 70) begin
			if ($urandom_range(0, 6) == 0) begin
				do len = $urandom_range(0, 12); while (len == RATE_LEN);
				pl = noise_bytes(len);
			end else begin
				case ($urandom_range(0, 6))
					0: rate = 0;
					1: rate = 1;
					2: rate = 1000;
					3: rate = $urandom_range(1001, 5000);
					4: rate = $urandom_range(1, 1000);
					5: rate = $urandom_range(1, 20);
					default: rate = $urandom;
				endcase
				pl = rate_bytes(rate);
			end
			send_frame(CMD_RATE, pl, flaw);
		end else if (kind < 85) begin
			do cmd = 8'($urandom); while (cmd == CMD_MONITOR || cmd == CMD_SETVAR ||
				cmd == CMD_RATE);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, BUFFER_BYTES) :
				$urandom_range(0, 12);
			send_frame(cmd, noise_bytes(len), flaw);
		end else if (kind < 92) begin
			send_oversize(8'($urandom), 16'($urandom_range(BUFFER_BYTES + 1, 65535)));
		end else begin
			repeat ($urandom_range(1, 6)) send_byte(quiet_byte());
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_period(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.set_period_dflt(v);
	endtask

	initial begin
		int          target;
		logic [15:0] dflt;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed frames
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(CMD_MONITOR, noise_bytes(0), FRAME_GOOD);
		send_frame(CMD_MONITOR, headed_bytes(8'd0, 1), FRAME_GOOD);
		send_frame(CMD_MONITOR, headed_bytes(8'd10, 51), FRAME_GOOD);
		send_frame(CMD_MONITOR, headed_bytes(8'd11, 56), FRAME_GOOD);
		send_frame(CMD_MONITOR, headed_bytes(8'd3, 10), FRAME_GOOD);
		send_frame(CMD_MONITOR, headed_bytes(8'd255, 4), FRAME_GOOD);
		send_frame(CMD_SETVAR, setvar_bytes(8'd0), FRAME_GOOD);
		send_frame(CMD_SETVAR, setvar_bytes(8'd8), FRAME_GOOD);
		send_frame(CMD_SETVAR, setvar_bytes(8'd7), FRAME_GOOD);
		send_frame(CMD_SETVAR, setvar_bytes(8'd9), FRAME_GOOD);
		send_frame(CMD_SETVAR, setvar_bytes(8'd255), FRAME_GOOD);
		send_frame(CMD_SETVAR, noise_bytes(8), FRAME_GOOD);
		send_frame(CMD_RATE, rate_bytes(32'd0), FRAME_GOOD);
		send_frame(CMD_RATE, rate_bytes(32'd1), FRAME_GOOD);
		send_frame(CMD_RATE, rate_bytes(32'd1000), FRAME_GOOD);
		send_frame(CMD_RATE, rate_bytes(32'd1001), FRAME_GOOD);
		send_frame(CMD_RATE, rate_bytes(32'hFFFF_FFFF), FRAME_GOOD);
		send_frame(CMD_RATE, noise_bytes(5), FRAME_GOOD);
		send_frame(8'h00, noise_bytes(0), FRAME_GOOD);
		send_frame(8'hFF, noise_bytes(BUFFER_BYTES), FRAME_GOOD);
		send_oversize(CMD_RATE, 16'(BUFFER_BYTES + 1));
		send_oversize(CMD_MONITOR, 16'hFFFF);
		send_frame(CMD_SETVAR, setvar_bytes(8'd1), FRAME_BAD_SUM);
		send_frame(CMD_RATE, rate_bytes(32'd50), FRAME_BAD_EOP);

		for (int ph = 0; ph < 5; ph++) begin
			settle();
			case (ph)
				0: dflt = 16'hFFFF;
				1: dflt = 16'd1;
				2: dflt = 16'd0;
				3: dflt = 16'($urandom_range(2, 65534));
				default: dflt = 16'd10;
			endcase
			write_period(dflt);
			tx_idle = (ph != 1 && ph != 3);
			rx_idle = (ph != 1 && ph != 2);
			if (ph == 2)
				hold_cycles = 600;
			send_frame(CMD_RATE, rate_bytes(32'd0), FRAME_GOOD);
			target = frame_bytes + 250;
			while (frame_bytes < target) send_random_frame();
		end

		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: command_frame_receiver_core.f
rtl/cfr_pkg.sv
rtl/cfr_ctrl.sv
rtl/cfr_datapath.sv
rtl/command_frame_receiver_core.sv
verif/command_frame_receiver_core_test.sv
